@@ sv/edeg_pkg.sv @@
`default_nettype none
package edeg_pkg;

   localparam int FRAC_BITS   = 23;
   localparam int SAMPLE_BITS = 16;

   localparam int VAL_W   = FRAC_BITS + 1;
   localparam int DIFF_W  = VAL_W + 1;
   localparam int PROD_W  = SAMPLE_BITS + DIFF_W;
   localparam int SHIFT_W = PROD_W - FRAC_BITS;
   localparam int TYPE_W  = 4;

   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = 32;

   localparam logic [VAL_W-1:0] ENV_ONE  = {1'b1, {FRAC_BITS{1'b0}}};
   localparam logic [VAL_W-1:0] ENV_ZERO = '0;

   typedef enum logic [TYPE_W-1:0] {
      REQ_SAMPLE  = 4'd0,
      REQ_ON      = 4'd1,
      REQ_RESET   = 4'd2,
      REQ_ATTACK  = 4'd3,
      REQ_HOLD    = 4'd4,
      REQ_DECAY   = 4'd5,
      REQ_SUSTAIN = 4'd6,
      REQ_RELEASE = 4'd7,
      REQ_OFF     = 4'd8
   } req_code_type;

   localparam logic [CSR_IDX_W-1:0] CSR_ATTACK_COEF  = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HOLD_COEF    = 8'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DECAY_COEF   = 8'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_RELEASE_COEF = 8'd3;

endpackage
`default_nettype wire

@@ sv/edeg_req_if.sv @@
`default_nettype none
interface edeg_req_if
   import edeg_pkg::*;
   ();
   logic                          valid;
   logic                          ready;
   logic [TYPE_W-1:0]             req_type;
   logic signed [SAMPLE_BITS-1:0] sample_in;
   logic                          block_end;

   modport source (output valid, output req_type, output sample_in, output block_end,
                   input ready);
   modport sink   (input valid, input req_type, input sample_in, input block_end,
                   output ready);
endinterface
`default_nettype wire

@@ sv/edeg_rsp_if.sv @@
`default_nettype none
interface edeg_rsp_if
   import edeg_pkg::*;
   ();
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample_out;
   logic                          block_end_out;

   modport source (output valid, output sample_out, output block_end_out, input ready);
   modport sink   (input valid, input sample_out, input block_end_out, output ready);
endinterface
`default_nettype wire

@@ sv/edeg_csr_if.sv @@
`default_nettype none
interface edeg_csr_if
   import edeg_pkg::*;
   ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  idx;
   logic [CSR_DATA_W-1:0] wdata;

   modport source (output valid, output idx, output wdata, input ready);
   modport sink   (input valid, input idx, input wdata, output ready);
endinterface
`default_nettype wire

@@ sv/edeg_scale.sv @@
`default_nettype none
module edeg_scale
   import edeg_pkg::*;
   (
   input  wire logic [VAL_W-1:0] env,
   input  wire logic [VAL_W-1:0] coef,
   output      logic [VAL_W-1:0] env_next
   );

   logic [2*VAL_W-1:0]        prod;
   logic [2*VAL_W-FRAC_BITS-1:0] shifted;

   // truncate after the multiply, clamp at one
   assign prod    = env * coef;
   assign shifted = prod[2*VAL_W-1:FRAC_BITS];

   always_comb begin
      if (shifted > {{(VAL_W-FRAC_BITS){1'b0}}, ENV_ONE}) begin
         env_next = ENV_ONE;
      end else begin
         env_next = shifted[VAL_W-1:0];
      end
   end

endmodule
`default_nettype wire

@@ sv/edeg_shape.sv @@
`default_nettype none
module edeg_shape
   import edeg_pkg::*;
   (
   input  wire logic signed [SAMPLE_BITS-1:0] sample,
   input  wire logic        [VAL_W-1:0]       env_fast,
   input  wire logic        [VAL_W-1:0]       env_slow,
   output      logic signed [SAMPLE_BITS-1:0] shaped
   );

   logic signed [DIFF_W-1:0]  diff;
   logic signed [PROD_W-1:0]  prod;
   logic signed [SHIFT_W-1:0] quot;
   logic                      in_range;

   assign diff = $signed({1'b0, env_fast}) - $signed({1'b0, env_slow});
   assign prod = sample * diff;
   // arithmetic shift rounds toward minus infinity
   assign quot = prod[PROD_W-1:FRAC_BITS];

   assign in_range = (quot[SHIFT_W-1:SAMPLE_BITS-1] == '0) ||
                     (quot[SHIFT_W-1:SAMPLE_BITS-1] == '1);

   always_comb begin
      if (in_range) begin
         shaped = quot[SAMPLE_BITS-1:0];
      end else if (quot[SHIFT_W-1]) begin
         shaped = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
      end else begin
         shaped = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
      end
   end

endmodule
`default_nettype wire

@@ sv/exp_difference_envelope_gen.sv @@
// Envelope generator: gain = e1 - e2, two decaying exponentials in Q1.23.
// req_bus carries words: a sample word (type sample) is multiplied by the
// current gain, saturated to 16 bits and sent on rsp_bus together with its
// block_end mark; afterwards e1 and e2 are each scaled by their coefficient.
// Command words (on, reset, attack, hold, decay, sustain, release, off)
// change envelope state and produce no rsp_bus word; codes 9-15 are dropped.
// csr_bus writes the attack, hold, decay and release coefficients (index
// 0 to 3, low 24 bits of the data kept); it is always ready. The user must
// make writes only while no word is in flight; the block does not enforce it.
// A sample word passes the input register, then the result register, to
// rsp_bus. Throughput: one word per cycle while rsp_bus does not stall;
// each envelope update loop holds one 24x24 multiply per cycle.
// When rsp_bus stalls, the result register holds its word and the input
// register keeps taking command words; a sample waits in the input register
// and req_bus.ready drops only once both registers are full.
// Reset (synchronous, active high) empties both registers and sets every
// coefficient register, e1, e2, c1 and c2 to 1.0.
`default_nettype none
module exp_difference_envelope_gen
   import edeg_pkg::*;
   (
   input wire logic  clock,
   input wire logic  reset,
   edeg_req_if.sink  req_bus,
   edeg_rsp_if.source rsp_bus,
   edeg_csr_if.sink  csr_bus
   );

   logic [VAL_W-1:0] attack_coef_ff,  attack_coef_in;
   logic [VAL_W-1:0] hold_coef_ff,    hold_coef_in;
   logic [VAL_W-1:0] decay_coef_ff,   decay_coef_in;
   logic [VAL_W-1:0] release_coef_ff, release_coef_in;

   logic [VAL_W-1:0] env_fast_ff,  env_fast_in;
   logic [VAL_W-1:0] env_slow_ff,  env_slow_in;
   logic [VAL_W-1:0] coef_fast_ff, coef_fast_in;
   logic [VAL_W-1:0] coef_slow_ff, coef_slow_in;

   logic                          in_vld_ff,    in_vld_in;
   logic [TYPE_W-1:0]             in_type_ff,   in_type_in;
   logic signed [SAMPLE_BITS-1:0] in_sample_ff, in_sample_in;
   logic                          in_end_ff,    in_end_in;

   logic                          out_vld_ff,    out_vld_in;
   logic signed [SAMPLE_BITS-1:0] out_sample_ff, out_sample_in;
   logic                          out_end_ff,    out_end_in;

   logic                          req_fire;
   logic                          is_sample;
   logic                          out_free;
   logic                          ex_go;
   logic [VAL_W-1:0]              env_fast_next;
   logic [VAL_W-1:0]              env_slow_next;
   logic signed [SAMPLE_BITS-1:0] shaped;
   logic [VAL_W-1:0]              csr_val;

   edeg_scale u_scale_fast (
      .env      (env_fast_ff),
      .coef     (coef_fast_ff),
      .env_next (env_fast_next)
   );

   edeg_scale u_scale_slow (
      .env      (env_slow_ff),
      .coef     (coef_slow_ff),
      .env_next (env_slow_next)
   );

   edeg_shape u_shape (
      .sample   (in_sample_ff),
      .env_fast (env_fast_ff),
      .env_slow (env_slow_ff),
      .shaped   (shaped)
   );

   // handshake
   assign is_sample     = (req_code_type'(in_type_ff) == REQ_SAMPLE);
   assign out_free      = !out_vld_ff || rsp_bus.ready;
   assign ex_go         = in_vld_ff && (!is_sample || out_free);
   assign req_bus.ready = !in_vld_ff || ex_go;
   assign req_fire      = req_bus.valid && req_bus.ready;

   assign rsp_bus.valid         = out_vld_ff;
   assign rsp_bus.sample_out    = out_sample_ff;
   assign rsp_bus.block_end_out = out_end_ff;

   assign csr_bus.ready = 1'b1;
   assign csr_val       = csr_bus.wdata[VAL_W-1:0];

   // input register
   always_comb begin
      in_vld_in    = in_vld_ff;
      in_type_in   = in_type_ff;
      in_sample_in = in_sample_ff;
      in_end_in    = in_end_ff;
      if (req_fire) begin
         in_vld_in    = 1'b1;
         in_type_in   = req_bus.req_type;
         in_sample_in = req_bus.sample_in;
         in_end_in    = req_bus.block_end;
      end else if (ex_go) begin
         in_vld_in = 1'b0;
      end
   end

   // result register
   always_comb begin
      out_vld_in    = out_vld_ff;
      out_sample_in = out_sample_ff;
      out_end_in    = out_end_ff;
      if (ex_go && is_sample) begin
         out_vld_in    = 1'b1;
         out_sample_in = shaped;
         out_end_in    = in_end_ff;
      end else if (rsp_bus.ready) begin
         out_vld_in = 1'b0;
      end
   end

   // envelope state
   always_comb begin
      env_fast_in  = env_fast_ff;
      env_slow_in  = env_slow_ff;
      coef_fast_in = coef_fast_ff;
      coef_slow_in = coef_slow_ff;
      if (ex_go) begin
         case (req_code_type'(in_type_ff))
            REQ_SAMPLE: begin
               env_fast_in = env_fast_next;
               env_slow_in = env_slow_next;
            end
            REQ_ON: begin
               env_fast_in  = ENV_ONE;
               env_slow_in  = ENV_ONE;
               coef_fast_in = ENV_ONE;
               coef_slow_in = ENV_ONE;
            end
            REQ_RESET: begin
               env_fast_in = ENV_ONE;
               env_slow_in = ENV_ONE;
            end
            REQ_ATTACK:  coef_slow_in = attack_coef_ff;
            REQ_HOLD:    coef_fast_in = hold_coef_ff;
            REQ_DECAY:   coef_fast_in = decay_coef_ff;
            REQ_SUSTAIN: coef_fast_in = ENV_ONE;
            REQ_RELEASE: coef_fast_in = release_coef_ff;
            REQ_OFF:     coef_fast_in = ENV_ZERO;
            default: begin
            end
         endcase
      end
   end

   // coefficient registers
   always_comb begin
      attack_coef_in  = attack_coef_ff;
      hold_coef_in    = hold_coef_ff;
      decay_coef_in   = decay_coef_ff;
      release_coef_in = release_coef_ff;
      if (csr_bus.valid) begin
         case (csr_bus.idx)
            CSR_ATTACK_COEF:  attack_coef_in  = csr_val;
            CSR_HOLD_COEF:    hold_coef_in    = csr_val;
            CSR_DECAY_COEF:   decay_coef_in   = csr_val;
            CSR_RELEASE_COEF: release_coef_in = csr_val;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff       <= 1'b0;
         out_vld_ff      <= 1'b0;
         env_fast_ff     <= ENV_ONE;
         env_slow_ff     <= ENV_ONE;
         coef_fast_ff    <= ENV_ONE;
         coef_slow_ff    <= ENV_ONE;
         attack_coef_ff  <= ENV_ONE;
         hold_coef_ff    <= ENV_ONE;
         decay_coef_ff   <= ENV_ONE;
         release_coef_ff <= ENV_ONE;
      end else begin
         in_vld_ff       <= in_vld_in;
         out_vld_ff      <= out_vld_in;
         env_fast_ff     <= env_fast_in;
         env_slow_ff     <= env_slow_in;
         coef_fast_ff    <= coef_fast_in;
         coef_slow_ff    <= coef_slow_in;
         attack_coef_ff  <= attack_coef_in;
         hold_coef_ff    <= hold_coef_in;
         decay_coef_ff   <= decay_coef_in;
         release_coef_ff <= release_coef_in;
      end
   end

   always_ff @(posedge clock) begin
      in_type_ff    <= in_type_in;
      in_sample_ff  <= in_sample_in;
      in_end_ff     <= in_end_in;
      out_sample_ff <= out_sample_in;
      out_end_ff    <= out_end_in;
   end

endmodule
`default_nettype wire
